/* hdl/lrg_pkg.sv */
// Shared types and constants for the line raster generator.
// Holds the request and pixel structs, the register map and the opcodes.
// No dependencies.
package lrg_pkg;

  localparam int PIX_W          = 11;
  localparam int COLOR_W        = 24;
  localparam int ADDR_W         = 32;
  localparam int WIDTH_W        = 12;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_IDX_W      = 1;
  localparam int COORD_BITS_DEF = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE  = 1'd1;

  localparam logic [WIDTH_W-1:0] FRAME_WIDTH_RST = 12'd240;
  localparam logic [ADDR_W-1:0]  FRAME_BASE_RST  = 32'd0;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [PIX_W-1:0]   start_x;
    logic [PIX_W-1:0]   start_y;
    logic [PIX_W-1:0]   end_x_in;
    logic [PIX_W-1:0]   end_y_in;
    logic [COLOR_W-1:0] pixel_color;
  } lrg_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [COLOR_W-1:0] out_color;
    logic [ADDR_W-1:0]  byte_address;
    logic               last_pixel;
  } lrg_out_t;

endpackage

/* hdl/lrg_tracer.sv */
// Bresenham line state: endpoint setup on load and one pixel advance per step.
// Presents the current pixel combinationally from its state registers.
// Depends on lrg_pkg.
module lrg_tracer
  import lrg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load_en,
  input  logic                  step_en,
  input  lrg_in_t               req,
  output logic                  active,
  output logic [COORD_BITS-1:0] px,
  output logic [COORD_BITS-1:0] py,
  output logic                  last,
  output logic [COLOR_W-1:0]    color
);

  localparam int ERR_W = COORD_BITS + 2;

  logic [COORD_BITS-1:0]   cur_major_r, cur_major_nxt;
  logic [COORD_BITS-1:0]   end_major_r, end_major_nxt;
  logic [COORD_BITS-1:0]   cur_minor_r, cur_minor_nxt;
  logic signed [ERR_W-1:0] error_term_r, error_term_nxt;
  logic [COORD_BITS-1:0]   delta_major_r, delta_major_nxt;
  logic [COORD_BITS-1:0]   delta_minor_r, delta_minor_nxt;
  logic                    minor_dec_r, minor_dec_nxt;
  logic                    steep_r, steep_nxt;
  logic                    active_r, active_nxt;
  logic [COLOR_W-1:0]      color_r, color_nxt;

  logic [COORD_BITS-1:0]   ax, ay, bx, by;
  logic [COORD_BITS-1:0]   dx_abs, dy_abs;
  logic                    steep;
  logic [COORD_BITS-1:0]   maj_a, min_a, maj_b, min_b;
  logic                    swap;
  logic [COORD_BITS-1:0]   maj_s, min_s, maj_e, min_e;
  logic signed [ERR_W-1:0] err_sub;

  // Load setup: order endpoints so the major coordinate rises
  always_comb begin
    ax     = COORD_BITS'(req.start_x);
    ay     = COORD_BITS'(req.start_y);
    bx     = COORD_BITS'(req.end_x_in);
    by     = COORD_BITS'(req.end_y_in);
    dx_abs = (ax > bx) ? (ax - bx) : (bx - ax);
    dy_abs = (ay > by) ? (ay - by) : (by - ay);
    steep  = dy_abs > dx_abs;
    maj_a  = steep ? ay : ax;
    min_a  = steep ? ax : ay;
    maj_b  = steep ? by : bx;
    min_b  = steep ? bx : by;
    swap   = maj_a > maj_b;
    maj_s  = swap ? maj_b : maj_a;
    min_s  = swap ? min_b : min_a;
    maj_e  = swap ? maj_a : maj_b;
    min_e  = swap ? min_a : min_b;
  end

  assign err_sub = error_term_r - $signed({2'b00, delta_minor_r});

  always_comb begin
    cur_major_nxt   = cur_major_r;
    end_major_nxt   = end_major_r;
    cur_minor_nxt   = cur_minor_r;
    error_term_nxt  = error_term_r;
    delta_major_nxt = delta_major_r;
    delta_minor_nxt = delta_minor_r;
    minor_dec_nxt   = minor_dec_r;
    steep_nxt       = steep_r;
    active_nxt      = active_r;
    color_nxt       = color_r;
    if (load_en) begin
      steep_nxt       = steep;
      cur_major_nxt   = maj_s;
      end_major_nxt   = maj_e;
      cur_minor_nxt   = min_s;
      delta_major_nxt = maj_e - maj_s;
      delta_minor_nxt = (min_s > min_e) ? (min_s - min_e) : (min_e - min_s);
      error_term_nxt  = $signed(ERR_W'((maj_e - maj_s) >> 1));
      minor_dec_nxt   = !(min_s < min_e);
      color_nxt       = req.pixel_color;
      active_nxt      = 1'b1;
    end else if (step_en) begin
      error_term_nxt = err_sub;
      if (err_sub[ERR_W-1]) begin
        cur_minor_nxt  = minor_dec_r ? (cur_minor_r - 1'b1) : (cur_minor_r + 1'b1);
        error_term_nxt = err_sub + $signed({2'b00, delta_major_r});
      end
      if (last) begin
        active_nxt = 1'b0;
      end else begin
        cur_major_nxt = cur_major_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_major_r   <= '0;
      end_major_r   <= '0;
      cur_minor_r   <= '0;
      error_term_r  <= '0;
      delta_major_r <= '0;
      delta_minor_r <= '0;
      minor_dec_r   <= 1'b0;
      steep_r       <= 1'b0;
      active_r      <= 1'b0;
      color_r       <= '0;
    end else begin
      cur_major_r   <= cur_major_nxt;
      end_major_r   <= end_major_nxt;
      cur_minor_r   <= cur_minor_nxt;
      error_term_r  <= error_term_nxt;
      delta_major_r <= delta_major_nxt;
      delta_minor_r <= delta_minor_nxt;
      minor_dec_r   <= minor_dec_nxt;
      steep_r       <= steep_nxt;
      active_r      <= active_nxt;
      color_r       <= color_nxt;
    end
  end

  assign active = active_r;
  assign px     = steep_r ? cur_minor_r : cur_major_r;
  assign py     = steep_r ? cur_major_r : cur_minor_r;
  assign last   = cur_major_r == end_major_r;
  assign color  = color_r;

endmodule

/* hdl/line_raster_generator_top.sv */
// Line raster generator: Bresenham line stepping with frame buffer addressing.
// Top level: handshakes, configuration registers and the two-stage address pipe.
// Depends on lrg_pkg and lrg_tracer.

// A load request sets up a line and gives no pixel; each step request on an
// active line gives one pixel, the last one flagged, after which the line goes
// idle. One request is taken per clock while in_stall is low, loads and steps
// alike. A taken step request's pixel passes two registered stages: the first
// forms y * frame_width in one multiplier, the second adds x, scales by three
// and adds frame_base. Up to two pixels are held in flight while out_stall is
// high; in_stall rises only when both stages are full and the output is
// stalled. A step request with no active line is taken and dropped.
module line_raster_generator_top
  import lrg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lrg_in_t               in_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lrg_out_t              out_rsp,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PROD_W = COORD_BITS + WIDTH_W;

  logic [WIDTH_W-1:0] frame_width_r;
  logic [ADDR_W-1:0]  frame_base_r;

  logic                  in_accept, load_en, step_en, active, last;
  logic [COORD_BITS-1:0] px, py;
  logic [COLOR_W-1:0]    color;
  logic                  adv2, adv1;

  logic                  s1_valid_r, s1_valid_nxt;
  logic [COORD_BITS-1:0] s1_x_r, s1_y_r;
  logic [COLOR_W-1:0]    s1_color_r;
  logic                  s1_last_r;
  logic [PROD_W-1:0]     s1_prod_r;
  logic                  out_valid_r, out_valid_nxt;
  lrg_out_t              out_rsp_r;
  logic [ADDR_W-1:0]     pix_index;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= FRAME_WIDTH_RST;
      frame_base_r  <= FRAME_BASE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH: frame_width_r <= cfg_wdata[WIDTH_W-1:0];
        CFG_FRAME_BASE:  frame_base_r  <= cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Output stage frees when empty or taken; stage one follows it
  assign adv2      = !out_valid_r || !out_stall;
  assign adv1      = !s1_valid_r || adv2;
  assign in_stall  = !adv1;
  assign in_accept = in_valid && adv1;
  assign load_en   = in_accept && (in_req.opcode == OP_LOAD);
  assign step_en   = in_accept && (in_req.opcode == OP_STEP) && active;

  lrg_tracer #(
    .COORD_BITS(COORD_BITS)
  ) u_tracer (
    .clk     (clk),
    .rst_n   (rst_n),
    .load_en (load_en),
    .step_en (step_en),
    .req     (in_req),
    .active  (active),
    .px      (px),
    .py      (py),
    .last    (last),
    .color   (color)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (adv1) begin
      s1_valid_nxt = step_en;
    end
    out_valid_nxt = out_valid_r;
    if (adv2) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage one: row offset in pixels
  always_ff @(posedge clk) begin
    if (step_en) begin
      s1_x_r     <= px;
      s1_y_r     <= py;
      s1_color_r <= color;
      s1_last_r  <= last;
      s1_prod_r  <= PROD_W'(py) * PROD_W'(frame_width_r);
    end
  end

  assign pix_index = ADDR_W'(s1_prod_r) + ADDR_W'(s1_x_r);

  // Stage two: three bytes per pixel, wrap at the address width
  always_ff @(posedge clk) begin
    if (adv2 && s1_valid_r) begin
      out_rsp_r.pixel_x      <= PIX_W'(s1_x_r);
      out_rsp_r.pixel_y      <= PIX_W'(s1_y_r);
      out_rsp_r.out_color    <= s1_color_r;
      out_rsp_r.byte_address <= frame_base_r + (pix_index << 1) + pix_index;
      out_rsp_r.last_pixel   <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

/* tb/sv/line_raster_generator_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for line_raster_generator_top: directed and random line requests,
// a request-level Bresenham predictor and an in-order pixel scoreboard.
// Depends on lrg_pkg and the line_raster_generator_top RTL.
module line_raster_generator_top_tb;
  import lrg_pkg::*;

  localparam int COORD_MAX   = (1 << PIX_W) - 1;
  localparam int PHASE_ITEMS = 128;
  localparam int SETTLE_CYC  = 8;
  localparam int HOLD_CYC    = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FIXED} chk_t;

  typedef struct packed {
    lrg_in_t  req;
    chk_t     chk;
    lrg_out_t pix;
  } dir_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  lrg_in_t               in_req    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  lrg_out_t              out_rsp;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state: frame registers and the line being traced
  logic [WIDTH_W-1:0] fb_width = FRAME_WIDTH_RST;
  logic [ADDR_W-1:0]  fb_base  = FRAME_BASE_RST;
  logic [PIX_W-1:0]   ln_major = '0;
  logic [PIX_W-1:0]   ln_end   = '0;
  logic [PIX_W-1:0]   ln_minor = '0;
  logic [PIX_W-1:0]   ln_dmaj  = '0;
  logic [PIX_W-1:0]   ln_dmin  = '0;
  logic [COLOR_W-1:0] ln_color = '0;
  int                 ln_err   = 0;
  bit                 ln_down  = 1'b0;
  bit                 ln_steep = 1'b0;
  bit                 ln_busy  = 1'b0;

  lrg_out_t expected_pixels[$];
  dir_row_t dir_rows[$];

  int cycle_cnt      = 0;
  int requests_sent  = 0;
  int loads_sent     = 0;
  int traced_items   = 0;
  int pixels_checked = 0;
  int bad_pixels     = 0;
  int settings_cnt   = 1;
  int stall_cycles   = 0;
  int src_calm       = 0;
  bit hold_req       = 1'b0;

  line_raster_generator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d pixels outstanding", cycle_cnt,
             expected_pixels.size());
    $display("status: fail");
    $finish;
  end

  function automatic logic [PIX_W-1:0] span(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Advance the line state by one request; a step on an active line yields a pixel.
  task automatic rasterize(input lrg_in_t r, output bit emits, output lrg_out_t pix);
    logic [PIX_W-1:0] ax, ay, bx, by;
    logic [PIX_W-1:0] px, py;
    bit steep;
    emits = 1'b0;
    pix   = '0;
    if (r.opcode == OP_LOAD) begin
      ax = r.start_x;
      ay = r.start_y;
      bx = r.end_x_in;
      by = r.end_y_in;
      steep = span(ay, by) > span(ax, bx);
      if (steep) begin
        {ax, ay} = {ay, ax};
        {bx, by} = {by, bx};
      end
      if (ax > bx) begin
        {ax, bx} = {bx, ax};
        {ay, by} = {by, ay};
      end
      ln_steep = steep;
      ln_major = ax;
      ln_end   = bx;
      ln_minor = ay;
      ln_dmaj  = bx - ax;
      ln_dmin  = span(ay, by);
      ln_err   = int'(ln_dmaj) / 2;
      ln_down  = !(ay < by);
      ln_color = r.pixel_color;
      ln_busy  = 1'b1;
    end else if (ln_busy) begin
      px = ln_steep ? ln_minor : ln_major;
      py = ln_steep ? ln_major : ln_minor;
      pix.pixel_x      = px;
      pix.pixel_y      = py;
      pix.out_color    = ln_color;
      pix.byte_address = fb_base + 32'd3 * (32'(py) * 32'(fb_width) + 32'(px));
      pix.last_pixel   = (ln_major == ln_end);
      emits = 1'b1;
      ln_err -= int'(ln_dmin);
      if (ln_err < 0) begin
        ln_minor = ln_down ? ln_minor - 1'b1 : ln_minor + 1'b1;
        ln_err += int'(ln_dmaj);
      end
      if (pix.last_pixel) ln_busy = 1'b0;
      else ln_major = ln_major + 1'b1;
    end
  endtask

  function automatic lrg_in_t noise_req();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(lrg_in_t)-1:0];
  endfunction

  // Step payload fields are don't-care, so fill them with noise
  function automatic lrg_in_t make_step();
    lrg_in_t r;
    r = noise_req();
    r.opcode = OP_STEP;
    return r;
  endfunction

  function automatic lrg_in_t make_load(input int x0, input int y0, input int x1, input int y1,
                                        input logic [COLOR_W-1:0] color);
    lrg_in_t r;
    r.opcode      = OP_LOAD;
    r.start_x     = PIX_W'(x0);
    r.start_y     = PIX_W'(y0);
    r.end_x_in    = PIX_W'(x1);
    r.end_y_in    = PIX_W'(y1);
    r.pixel_color = color;
    return r;
  endfunction

  function automatic lrg_out_t make_pix(input int x, input int y, input logic [COLOR_W-1:0] color,
                                        input logic [ADDR_W-1:0] addr, input bit last);
    lrg_out_t p;
    p.pixel_x      = PIX_W'(x);
    p.pixel_y      = PIX_W'(y);
    p.out_color    = color;
    p.byte_address = addr;
    p.last_pixel   = last;
    return p;
  endfunction

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  function automatic int pick_coord();
    if ($urandom_range(0, 6) == 0) return ($urandom_range(0, 1) == 1) ? COORD_MAX : 0;
    return $urandom_range(0, COORD_MAX);
  endfunction

  task automatic add_row(input lrg_in_t r, input chk_t chk, input lrg_out_t pix);
    dir_row_t row;
    row.req = r;
    row.chk = chk;
    row.pix = pix;
    dir_rows.push_back(row);
  endtask

  // Offer one request after a random gap, hold it until taken, then predict.
  task automatic send_request(input lrg_in_t r, input chk_t chk, input lrg_out_t fixed);
    int gap;
    bit emits;
    lrg_out_t pix;
    if (src_calm > 0) begin
      src_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 24) == 0) src_calm = $urandom_range(15, 50);
      gap = $urandom_range(0, 7);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    rasterize(r, emits, pix);
    requests_sent++;
    if (r.opcode == OP_LOAD) loads_sent++;
    if (r.opcode == OP_LOAD || emits) traced_items++;
    case (chk)
      CHK_MODEL: if (emits) expected_pixels.push_back(pix);
      CHK_FIXED: expected_pixels.push_back(fixed);
      default: ;
    endcase
  endtask

  // Load a line and step it; broken sequences stop early and leave the line hanging.
  task automatic send_line(input bit broken);
    int x0, y0, x1, y1, lim, cap, n, cls;
    cls = $urandom_range(0, 99);
    x0  = pick_coord();
    y0  = pick_coord();
    if (cls < 7) begin
      x1  = $urandom_range(0, COORD_MAX);
      y1  = $urandom_range(0, COORD_MAX);
      cap = $urandom_range(1, 80);
    end else begin
      lim = (cls < 25) ? 150 : 12;
      x1  = clamp_coord(x0 + int'($urandom_range(0, 2 * lim)) - lim);
      y1  = clamp_coord(y0 + int'($urandom_range(0, 2 * lim)) - lim);
      cap = 1 << 20;
    end
    if (broken) cap = $urandom_range(0, 6);
    send_request(make_load(x0, y0, x1, y1, COLOR_W'($urandom)), CHK_MODEL, '0);
    n = 0;
    while (ln_busy && n < cap) begin
      send_request(make_step(), CHK_MODEL, '0);
      n++;
    end
    // extra step: it must be dropped if the line has already ended
    if ($urandom_range(0, 9) == 0) send_request(make_step(), CHK_MODEL, '0);
  endtask

  task automatic random_phase(input int n);
    int base_cnt, pick;
    base_cnt = traced_items;
    while (traced_items - base_cnt < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) send_line(1'b0);
      else if (pick < 90) send_line(1'b1);
      else send_request(noise_req(), CHK_MODEL, '0);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] wword, input logic [ADDR_W-1:0] base);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_wdata <= wword;
    @(posedge clk);
    fb_width = wword[WIDTH_W-1:0];
    cfg_index <= CFG_FRAME_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    fb_base = base;
    cfg_wr_en <= 1'b0;
    settings_cnt++;
  endtask

  // Pixel sink: random stalls, quiet stretches, and a long hold-off on request.
  initial begin : pixel_sink
    int hold;
    int calm;
    calm = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold     = HOLD_CYC;
        hold_req = 1'b0;
      end else if (calm > 0) begin
        hold = 0;
        calm--;
      end else begin
        if ($urandom_range(0, 19) == 0) calm = $urandom_range(20, 60);
        hold = $urandom_range(0, 7);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : pixel_check
    lrg_out_t want;
    if (rst_n && in_valid && in_stall) stall_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      pixels_checked++;
      if (expected_pixels.size() == 0) begin
        bad_pixels++;
        if (bad_pixels <= 10)
          $display("unexpected pixel x=%0d y=%0d c=%06h a=%08h l=%0b", out_rsp.pixel_x,
                   out_rsp.pixel_y, out_rsp.out_color, out_rsp.byte_address,
                   out_rsp.last_pixel);
      end else begin
        want = expected_pixels.pop_front();
        if (out_rsp.pixel_x !== want.pixel_x || out_rsp.pixel_y !== want.pixel_y ||
            out_rsp.out_color !== want.out_color ||
            out_rsp.byte_address !== want.byte_address ||
            out_rsp.last_pixel !== want.last_pixel) begin
          bad_pixels++;
          if (bad_pixels <= 10) begin
            $display("pixel mismatch: want x=%0d y=%0d c=%06h a=%08h l=%0b",
                     want.pixel_x, want.pixel_y, want.out_color, want.byte_address,
                     want.last_pixel);
            $display("                got  x=%0d y=%0d c=%06h a=%08h l=%0b",
                     out_rsp.pixel_x, out_rsp.pixel_y, out_rsp.out_color,
                     out_rsp.byte_address, out_rsp.last_pixel);
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] wword;
    // Reset-default frame: width 240, base 0
    add_row(make_step(), CHK_NONE, '0);
    add_row(make_load(0, 0, 0, 0, 24'hFFFFFF), CHK_NONE, '0);
    add_row(make_step(), CHK_FIXED, make_pix(0, 0, 24'hFFFFFF, 32'd0, 1'b1));
    add_row(make_step(), CHK_NONE, '0);
    add_row(make_load(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 24'h000000), CHK_NONE, '0);
    add_row(make_step(), CHK_FIXED, make_pix(COORD_MAX, COORD_MAX, 24'h000000, 32'd1479981,
                                             1'b1));
    add_row(make_load(0, 0, COORD_MAX, 0, 24'hA5A5A5), CHK_NONE, '0);
    add_row(make_step(), CHK_FIXED, make_pix(0, 0, 24'hA5A5A5, 32'd0, 1'b0));
    add_row(make_step(), CHK_FIXED, make_pix(1, 0, 24'hA5A5A5, 32'd3, 1'b0));
    // abandon the long line with a steep one running backwards
    add_row(make_load(5, 10, 2, 3, 24'h123456), CHK_NONE, '0);
    repeat (8) add_row(make_step(), CHK_MODEL, '0);
    add_row(make_step(), CHK_NONE, '0);
    add_row(make_load(0, COORD_MAX, COORD_MAX, 0, 24'h00FF00), CHK_MODEL, '0);
    repeat (2) add_row(make_step(), CHK_MODEL, '0);
    add_row(make_load(COORD_MAX, 0, 0, 5, 24'h5A5A5A), CHK_MODEL, '0);
    repeat (2) add_row(make_step(), CHK_MODEL, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].pix);
    random_phase(PHASE_ITEMS);

    for (int ph = 1; ph < 7; ph++) begin
      drain();
      wword = $urandom;
      wword[WIDTH_W-1:0] = WIDTH_W'($urandom_range(1, 2048));
      case (ph)
        1: set_frame(32'd1, 32'hFFFF_FFFF);
        2: set_frame(32'd2048, $urandom);
        3: set_frame(32'd0, $urandom);
        4: set_frame(32'd4095, 32'hFFFF_FF00);
        5: set_frame(wword, $urandom);
        default: set_frame(32'd640, 32'd0);
      endcase
      // starve the output for a while so the request side backs up
      if (ph == 2 || ph == 5) hold_req = 1'b1;
      random_phase(PHASE_ITEMS);
    end

    drain();
    $display("ran %0d requests (%0d loads) over %0d frame settings, %0d pixels checked",
             requests_sent, loads_sent, settings_cnt, pixels_checked);
    $display("input stalled %0d cycles under output hold-off, %0d bad pixels",
             stall_cycles, bad_pixels);
    if (bad_pixels == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* line_raster_generator_top.f */
hdl/lrg_pkg.sv
hdl/lrg_tracer.sv
hdl/line_raster_generator_top.sv
tb/sv/line_raster_generator_top_tb.sv
